// ----- rtl/altitude_moving_average_unit_defines.svh -----
// Assertion macros shared by the checker of the altitude moving average unit.
// Needs a clock named clk and a synchronous reset named rst in the using scope.
`ifndef ALTITUDE_MOVING_AVERAGE_UNIT_DEFINES_SVH
`define ALTITUDE_MOVING_AVERAGE_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define AMAVG_CHK_SAME(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define AMAVG_CHK_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

// Consequent checked in the cycle after a reset cycle.
`define AMAVG_CHK_RESET(label, post, msg) \
  label: assert property (@(posedge clk) rst |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/amavg_pkg.sv -----
// Package of the altitude moving average unit: field widths, defaults,
// operation codes, controller states and the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

package amavg_pkg;

  localparam int ALT_W           = 24;
  localparam int FILT_W          = 24;
  localparam int REL_W           = 25;
  localparam int WINDOW_DEF      = 16;
  localparam int SAMPLE_BITS_DEF = 24;

  localparam logic OP_FILTER  = 1'b0;
  localparam logic OP_CAPTURE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SET_REF,
    ST_READ,
    ST_UPDATE,
    ST_DIV_LOAD,
    ST_DIVIDE,
    ST_DIV_END,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;        // capture the input beat
    logic acc_sample;  // read oldest entry, add new sample to the sum
    logic update;      // retire oldest entry, store the sample, advance slot
    logic div_load;    // load the divider from the running sum
    logic div_step;    // one restoring division step
    logic mean;        // apply the sign and store the mean
    logic capture;     // latch the sample as reference altitude
    logic finish;      // load the output register
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/amavg_sample_if.sv -----
// Input channel of the altitude moving average unit: valid/ready plus payload.
// Depends on amavg_pkg for the field width.
`timescale 1ns / 1ps
`default_nettype none

interface amavg_sample_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic signed [amavg_pkg::ALT_W-1:0] altitude_cm;

  modport source (output valid, output op, output altitude_cm, input ready);
  modport sink (input valid, input op, input altitude_cm, output ready);
endinterface

`default_nettype wire

// ----- rtl/amavg_result_if.sv -----
// Output channel of the altitude moving average unit: valid/ready plus payload.
// Depends on amavg_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface amavg_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [amavg_pkg::FILT_W-1:0] filtered_cm;
  logic signed [amavg_pkg::REL_W-1:0]  relative_cm;

  modport source (output valid, output filtered_cm, output relative_cm, input ready);
  modport sink (input valid, input filtered_cm, input relative_cm, output ready);
endinterface

`default_nettype wire

// ----- rtl/amavg_ctrl.sv -----
// Controller of the altitude moving average unit: sequences one item at a time
// and owns the handshake flags. Depends on amavg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module amavg_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_op,
  output logic                    in_ready,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output amavg_pkg::cmd_t         cmd,
  input  wire amavg_pkg::status_t status
);

  amavg_pkg::state_t state, state_next;
  logic              out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= amavg_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      amavg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_op == amavg_pkg::OP_CAPTURE) begin
            state_next = amavg_pkg::ST_SET_REF;
          end else begin
            state_next = amavg_pkg::ST_READ;
          end
        end
      end
      amavg_pkg::ST_SET_REF: begin
        cmd.capture = 1'b1;
        state_next  = amavg_pkg::ST_FINISH;
      end
      amavg_pkg::ST_READ: begin
        cmd.acc_sample = 1'b1;
        state_next     = amavg_pkg::ST_UPDATE;
      end
      amavg_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = amavg_pkg::ST_DIV_LOAD;
      end
      amavg_pkg::ST_DIV_LOAD: begin
        cmd.div_load = 1'b1;
        state_next   = amavg_pkg::ST_DIVIDE;
      end
      amavg_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = amavg_pkg::ST_DIV_END;
        end
      end
      amavg_pkg::ST_DIV_END: begin
        cmd.mean   = 1'b1;
        state_next = amavg_pkg::ST_FINISH;
      end
      amavg_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = amavg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = amavg_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/amavg_datapath.sv -----
// Datapath of the altitude moving average unit: sample window memory, running
// sum, restoring divider, reference and output registers. Depends on amavg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module amavg_datapath #(
  parameter int WINDOW      = amavg_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = amavg_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire amavg_pkg::cmd_t                     cmd,
  output amavg_pkg::status_t                       status,
  input  wire logic signed [amavg_pkg::ALT_W-1:0]  altitude_cm,
  output logic signed [amavg_pkg::FILT_W-1:0]      filtered_cm,
  output logic signed [amavg_pkg::REL_W-1:0]       relative_cm
);

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW) + 1;
  localparam int STEP_W = $clog2(SUM_W);
  localparam int RAW_W  = (SAMPLE_BITS > amavg_pkg::ALT_W) ? SAMPLE_BITS : amavg_pkg::ALT_W;
  localparam int EXT_W  = (SAMPLE_BITS + 1 > amavg_pkg::REL_W) ? SAMPLE_BITS + 1
                                                               : amavg_pkg::REL_W;

  logic        [SAMPLE_BITS-1:0] win_mem [WINDOW];
  logic signed [SAMPLE_BITS-1:0] old_sample;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic signed [SUM_W-1:0]       window_sum;
  logic        [CNT_W-1:0]       fill_count;
  logic        [SLOT_W-1:0]      oldest_slot;
  logic signed [SAMPLE_BITS-1:0] reference_cm;
  logic signed [SAMPLE_BITS-1:0] last_mean;
  logic        [SUM_W-1:0]       div_num;
  logic        [CNT_W-1:0]       div_rem;
  logic                          div_neg;
  logic        [STEP_W-1:0]      div_count;

  logic [RAW_W-1:0] alt_raw;
  logic             full;
  logic [SUM_W-1:0] sum_abs;
  logic [CNT_W:0]   trial;
  logic [CNT_W:0]   diff;
  logic             take;
  logic [SUM_W-1:0] quot_signed;
  logic signed [EXT_W-1:0] mean_ext;
  logic signed [EXT_W-1:0] ref_ext;
  logic signed [EXT_W-1:0] rel_ext;

  // Bits above the input field read as zero; the sample sign comes from its top bit.
  assign alt_raw     = RAW_W'(unsigned'(altitude_cm));
  assign full        = (fill_count == CNT_W'(WINDOW));
  assign sum_abs     = window_sum[SUM_W-1] ? SUM_W'(-window_sum) : SUM_W'(window_sum);
  assign trial       = {div_rem, div_num[SUM_W-1]};
  assign diff        = trial - {1'b0, fill_count};
  assign take        = (trial >= {1'b0, fill_count});
  assign quot_signed = div_neg ? (~div_num + 1'b1) : div_num;
  assign mean_ext    = EXT_W'(last_mean);
  assign ref_ext     = EXT_W'(reference_cm);
  assign rel_ext     = mean_ext - ref_ext;

  assign status.div_done = (div_count == STEP_W'(SUM_W - 1));

  // Window memory: one read and one write port, registered read data.
  always_ff @(posedge clk) begin
    if (cmd.acc_sample) begin
      old_sample <= win_mem[oldest_slot];
    end
    if (cmd.update) begin
      win_mem[oldest_slot] <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum   <= '0;
      fill_count   <= '0;
      oldest_slot  <= '0;
      reference_cm <= '0;
      last_mean    <= '0;
    end else begin
      if (cmd.acc_sample) begin
        window_sum <= window_sum + SUM_W'(sample);
      end
      if (cmd.update) begin
        if (full) begin
          window_sum <= window_sum - SUM_W'(old_sample);
        end else begin
          fill_count <= fill_count + 1'b1;
        end
        if (oldest_slot == SLOT_W'(WINDOW - 1)) begin
          oldest_slot <= '0;
        end else begin
          oldest_slot <= oldest_slot + 1'b1;
        end
      end
      if (cmd.capture) begin
        reference_cm <= sample;
      end
      if (cmd.mean) begin
        last_mean <= quot_signed[SAMPLE_BITS-1:0];
      end
    end
  end

  // Payload registers: sample latch, divider and output.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample <= alt_raw[SAMPLE_BITS-1:0];
    end
    if (cmd.div_load) begin
      div_num   <= sum_abs;
      div_neg   <= window_sum[SUM_W-1];
      div_rem   <= '0;
      div_count <= '0;
    end else if (cmd.div_step) begin
      div_count <= div_count + 1'b1;
      div_num   <= {div_num[SUM_W-2:0], take};
      div_rem   <= take ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
    end
    if (cmd.finish) begin
      filtered_cm <= mean_ext[amavg_pkg::FILT_W-1:0];
      relative_cm <= rel_ext[amavg_pkg::REL_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/altitude_moving_average_unit.sv -----
// Top level of the altitude moving average unit: joins the controller and the
// datapath to the two channels. Depends on amavg_pkg and the channel interfaces.
//
//   Channel   Direction   Beat payload
//   sample    in          op (filter or capture), altitude_cm (24-bit signed)
//   result    out         filtered_cm (24-bit signed), relative_cm (25-bit signed)
//
// A filter beat passes through read, update, divider load, the bit-serial restoring
// divider, which takes one step per bit of SUM_W = SAMPLE_BITS + clog2(WINDOW) + 1,
// then mean and finish; a capture beat sets the reference and then finishes.
// Reset clears the sum, fill count, slot pointer, reference and last mean.
// A stalled result waits in the output register; the next sample beat may be
// taken meanwhile, and its result waits until the stalled one has gone.
`timescale 1ns / 1ps
`default_nettype none

module altitude_moving_average_unit #(
  parameter int WINDOW      = amavg_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = amavg_pkg::SAMPLE_BITS_DEF
) (
  input wire logic        clk,
  input wire logic        rst,
  amavg_sample_if.sink    sample,
  amavg_result_if.source  result
);

  // Commands from the controller, status back from the datapath.
  amavg_pkg::cmd_t    cmd;
  amavg_pkg::status_t status;

  // Filter beats go read, update, divide, finish; capture beats go set-ref, finish.
  amavg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_op     (sample.op),
    .in_ready  (sample.ready),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .cmd       (cmd),
    .status    (status)
  );

  // The datapath holds the window, the running sum and the divider. The mean is
  // truncated toward zero by dividing the magnitude and restoring the sign.
  amavg_datapath #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .altitude_cm (sample.altitude_cm),
    .filtered_cm (result.filtered_cm),
    .relative_cm (result.relative_cm)
  );

endmodule

`default_nettype wire

// ----- rtl/amavg_checker.sv -----
// Port-level checker of the altitude moving average unit, bound to the top level.
// Depends on altitude_moving_average_unit_defines.svh for the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "altitude_moving_average_unit_defines.svh"

module amavg_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [amavg_pkg::FILT_W-1:0]      out_filtered,
  input wire logic [amavg_pkg::REL_W-1:0]       out_relative
);

  `AMAVG_CHK_RESET(a_reset_no_result, !out_valid, "result valid right after reset")
  `AMAVG_CHK_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "sample taken twice")
  `AMAVG_CHK_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid), "result too early")
  `AMAVG_CHK_SAME(a_result_after_busy, $rose(out_valid), $past(!in_ready), "result while idle")
  `AMAVG_CHK_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(out_filtered) && $stable(out_relative), "stalled result changed")

endmodule

bind altitude_moving_average_unit amavg_checker u_amavg_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (sample.valid),
  .in_ready     (sample.ready),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .out_filtered (result.filtered_cm),
  .out_relative (result.relative_cm)
);

`default_nettype wire

// ----- tb/altitude_moving_average_unit_checker.sv -----
// Checker for the altitude moving average unit: watches both channels, keeps its
// own running-average model of the block and compares every result beat with it.
// Depends on amavg_pkg and the amavg_sample_if and amavg_result_if interfaces.
`timescale 1ns / 1ps

module altitude_moving_average_unit_checker
  import amavg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  amavg_sample_if   sample,
  amavg_result_if   result,
  output int        mismatches,
  output int        pending,
  output int        filter_beats,
  output int        capture_beats,
  output int        results_checked
);

  localparam int DEPTH        = WINDOW_DEF;

  typedef struct packed {
    logic signed [FILT_W-1:0] filtered_cm;
    logic signed [REL_W-1:0]  relative_cm;
  } average_beat_t;

  logic signed [ALT_W-1:0]  window_samples [DEPTH];
  longint                   running_sum;
  int                       samples_held;
  int                       next_slot;
  logic signed [ALT_W-1:0]  reference_alt;
  logic signed [FILT_W-1:0] current_mean;
  average_beat_t            awaited_results [$];
  average_beat_t            oldest;
  int                       mismatch_count;
  int                       filter_count;
  int                       capture_count;
  int                       result_count;

  // Applies one sample beat to the model and returns the result it should give.
  function automatic average_beat_t advance_average(input logic op,
                                                    input logic signed [ALT_W-1:0] alt);
    average_beat_t beat;
    longint        quotient;
    if (op == OP_CAPTURE) begin
      reference_alt = alt;
    end else begin
      // Once the window is full the oldest sample drops out of the sum.
      if (samples_held >= DEPTH) begin
        running_sum -= window_samples[next_slot];
      end else begin
        samples_held++;
      end
      window_samples[next_slot] = alt;
      running_sum += alt;
      next_slot = (next_slot + 1) % DEPTH;
      // Signed division truncates toward zero.
      quotient = running_sum / samples_held;
      current_mean = FILT_W'(quotient);
    end
    beat.filtered_cm = current_mean;
    beat.relative_cm = REL_W'(longint'(current_mean) - longint'(reference_alt));
    return beat;
  endfunction

  task automatic check_field(input string field_name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field_name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      running_sum    = 0;
      samples_held   = 0;
      next_slot      = 0;
      reference_alt  = '0;
      current_mean   = '0;
      awaited_results.delete();
      mismatch_count = 0;
      filter_count   = 0;
      capture_count  = 0;
      result_count   = 0;
    end else begin
      // Results are retired before new beats are predicted, so a result can
      // never be matched against the beat accepted at the same edge.
      if (result.valid && result.ready) begin
        result_count++;
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result beat: expected none, actual %0d / %0d",
                   $time, result.filtered_cm, result.relative_cm);
        end else begin
          oldest = awaited_results.pop_front();
          check_field("filtered_cm", oldest.filtered_cm, result.filtered_cm);
          check_field("relative_cm", oldest.relative_cm, result.relative_cm);
        end
      end
      if (sample.valid && sample.ready) begin
        if (sample.op == OP_CAPTURE) begin
          capture_count++;
        end else begin
          filter_count++;
        end
        awaited_results.push_back(advance_average(sample.op, sample.altitude_cm));
      end
    end
    mismatches      <= mismatch_count;
    pending         <= awaited_results.size();
    filter_beats    <= filter_count;
    capture_beats   <= capture_count;
    results_checked <= result_count;
  end

endmodule

// ----- tb/altitude_moving_average_unit_test.sv -----
// Top of the altitude moving average unit testbench: clock, reset, stimulus on
// the sample channel, back-pressure on the result channel and the verdict.
// Depends on amavg_pkg, both channel interfaces, the unit and its checker.
`timescale 1ns / 1ps

module altitude_moving_average_unit_test;
  import amavg_pkg::*;

  localparam int RESET_CYCLES     = 9;
  localparam int RANDOM_PER_PHASE = 125;
  localparam int BURST_BEATS      = 20;
  // The long hold far outlasts a filter beat, so the unit ends up with one result
  // parked in its output register and another one waiting.
  localparam int LONG_HOLD        = 300;
  // Quiet time at the end, well beyond the filter latency, to catch a stray beat.
  localparam int SETTLE_CYCLES    = 60;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int CAPTURE_PCT      = 12;

  // Idling phases: steady, sender idle, receiver stalling, both a little.
  localparam int IDLE_BY_PHASE  [4] = '{0, 55, 0, 7};
  localparam int STALL_BY_PHASE [4] = '{0, 0, 55, 7};

  localparam logic signed [ALT_W-1:0] ALT_MAX = {1'b0, {(ALT_W-1){1'b1}}};
  localparam logic signed [ALT_W-1:0] ALT_MIN = {1'b1, {(ALT_W-1){1'b0}}};

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Percentages read each cycle by the sender and the receiver.
  int idle_pct      = 0;
  int stall_pct     = 0;
  // The stimulus asks for a long hold by bumping the request count; the
  // receiver process owns the served count and the hold itself.
  int hold_requests = 0;
  int holds_served  = 0;
  int cycle_count   = 0;

  int mismatches;
  int pending;
  int filter_beats;
  int capture_beats;
  int results_checked;

  amavg_sample_if sample_ch ();
  amavg_result_if result_ch ();

  altitude_moving_average_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch)
  );

  altitude_moving_average_unit_checker average_checker (
    .clk             (clk),
    .rst             (rst),
    .sample          (sample_ch),
    .result          (result_ch),
    .mismatches      (mismatches),
    .pending         (pending),
    .filter_beats    (filter_beats),
    .capture_beats   (capture_beats),
    .results_checked (results_checked)
  );

  always #1 clk = ~clk;

  // Picks an altitude: the extremes and values next to them, small values
  // around zero (where truncation toward zero shows up in negative means),
  // and full-range random words so that every bit takes both values.
  function automatic logic signed [ALT_W-1:0] pick_altitude();
    logic signed [ALT_W-1:0] near_zero;
    case ($urandom_range(7))
      0: return ALT_MAX;
      1: return ALT_MIN;
      2: return ALT_MAX - ALT_W'($urandom_range(100));
      3: return ALT_MIN + ALT_W'($urandom_range(100));
      4, 5: begin
        near_zero = ALT_W'($urandom_range(600));
        return near_zero - 24'sd300;
      end
      default: return ALT_W'($urandom());
    endcase
  endfunction

  // Offers one beat and holds it until it is accepted. Afterwards the sender
  // may idle for some cycles; while idle the payload is scrambled, since the
  // unit must not look at it without valid.
  task automatic send_beat(input logic op, input logic signed [ALT_W-1:0] alt);
    sample_ch.valid       <= 1'b1;
    sample_ch.op          <= op;
    sample_ch.altitude_cm <= alt;
    do @(posedge clk); while (sample_ch.ready !== 1'b1);
    while ($urandom_range(99) < idle_pct) begin
      sample_ch.valid       <= 1'b0;
      sample_ch.op          <= 1'($urandom_range(1));
      sample_ch.altitude_cm <= ALT_W'($urandom());
      @(posedge clk);
    end
  endtask

  task automatic send_random_beat();
    send_beat(($urandom_range(99) < CAPTURE_PCT) ? OP_CAPTURE : OP_FILTER, pick_altitude());
  endtask

  // Drops valid and waits until every predicted result has come back. The
  // checker publishes its count with a nonblocking update, so the value read
  // here is the one from before the edge and includes the last accepted beat.
  task automatic wait_drained();
    sample_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Receiver: random stalls at the current rate, or one long hold when asked.
  initial begin
    int hold_cycles;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        result_ch.ready <= 1'b0;
        for (hold_cycles = 0; hold_cycles < LONG_HOLD; hold_cycles++) @(posedge clk);
        holds_served++;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
    $display("altitude_moving_average_unit_test failed");
    $finish;
  end

  initial begin
    int phase;
    int n;
    sample_ch.valid       = 1'b0;
    sample_ch.op          = OP_FILTER;
    sample_ch.altitude_cm = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. A capture before any filtered sample must report a zero
    // mean against the new reference.
    send_beat(OP_CAPTURE, ALT_MAX);
    // A first sample at the most negative value is its own mean.
    send_beat(OP_FILTER, ALT_MIN);
    // Captures leave the mean alone and only move the reference.
    send_beat(OP_CAPTURE, ALT_MIN);
    send_beat(OP_CAPTURE, ALT_MAX);
    // Sum of -1 over two samples: the mean truncates toward zero, not down.
    send_beat(OP_FILTER, ALT_MAX);
    // Fill the window with the largest value and wrap once, which retires the
    // negative sample and leaves a full window of maxima.
    for (n = 0; n < 15; n++) send_beat(OP_FILTER, ALT_MAX);
    // Largest mean against the smallest reference gives the top of relative_cm.
    send_beat(OP_CAPTURE, ALT_MIN);
    // Wrapped window with a mix of extremes, then values around zero.
    send_beat(OP_FILTER, ALT_MIN);
    send_beat(OP_FILTER, -24'sd1);
    send_beat(OP_FILTER, 24'sd0);
    wait_drained();

    // Random part, one block per idling phase, each ending with the sender
    // paused until every result is back.
    for (phase = 0; phase < 4; phase++) begin
      idle_pct  = IDLE_BY_PHASE[phase];
      stall_pct = STALL_BY_PHASE[phase];
      for (n = 0; n < RANDOM_PER_PHASE; n++) send_random_beat();
      wait_drained();
    end

    // Back-pressure: the receiver holds off while the sender keeps offering
    // beats back to back, so the unit fills up and stops taking samples.
    idle_pct  = 0;
    stall_pct = 0;
    hold_requests++;
    for (n = 0; n < BURST_BEATS; n++) send_random_beat();
    wait_drained();

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d filter and %0d capture beats, %0d result beats checked,",
             filter_beats, capture_beats, results_checked);
    $display("over steady, sender-idle, receiver-stall and mixed phases and one long hold.");
    if (mismatches == 0 && pending == 0) begin
      $display("altitude_moving_average_unit_test passed");
    end else begin
      $display("altitude_moving_average_unit_test failed");
    end
    $finish;
  end

endmodule
